// File: hw/rtl/bloom_filter_engine_defines.svh
// assertion macros shared by the bloom filter engine rtl
// checks sample on clk; BFE_CHECK stays quiet while rst_n is low, BFE_CHECK_ALWAYS does not
`ifndef BLOOM_FILTER_ENGINE_DEFINES_SVH
`define BLOOM_FILTER_ENGINE_DEFINES_SVH

`ifndef SYNTH
`define BFE_CHECK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BFE_CHECK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFE_CHECK(label, prop, msg)
`define BFE_CHECK_ALWAYS(label, prop, msg)
`endif

`endif

// File: hw/rtl/bfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bfe_pkg;

    // operation codes carried by an item
    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_QUERY = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // configuration register indexes
    localparam int CFG_W        = 17;
    localparam int CFG_INDEX_W  = 1;
    localparam int BIT_COUNT_W  = 17;
    localparam int HASH_COUNT_W = 5;
    localparam logic [CFG_INDEX_W-1:0] REG_BIT_COUNT  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_HASH_COUNT = 1'b1;

    // hash mixing constants
    localparam int          HASH_W      = 32;
    localparam logic [31:0] GOLDEN      = 32'h9e37_79b9;
    localparam int          MIX_SHIFT_A = 16;
    localparam int          MIX_SHIFT_B = 13;

    // modulo unit: quotient bits retired per cycle
    localparam int DIV_STEP_BITS = 4;
    localparam int DIV_STEPS     = HASH_W / DIV_STEP_BITS;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS + 1);

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic mix;
        logic div_start;
        logic rd;
        logic set_bit;
        logic next_probe;
        logic clr_step;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_done;
        logic bit_hit;
        logic addr_ok;
        logic clr_last;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/bfe_mod_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module bfe_mod_unit
    import bfe_pkg::*;
#(
    parameter int NB_W = 17
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [HASH_W-1:0] dividend,
    input  wire logic [NB_W-1:0]   divisor,
    output logic                   done,
    output logic [NB_W-1:0]        rem
);

    localparam int REM_W = NB_W + 1;

    logic [DIV_CNT_W-1:0] step_reg;
    logic [HASH_W-1:0]    dvd_reg;
    logic [HASH_W-1:0]    dvd_next;
    logic [REM_W-1:0]     rem_reg;
    logic [REM_W-1:0]     rem_next;
    logic [REM_W-1:0]     dsor;

    assign dsor = {1'b0, divisor};

    // restoring division, several quotient bits per cycle, remainder kept only
    always_comb
    begin
        logic [REM_W-1:0]  r;
        logic [HASH_W-1:0] d;
        r = rem_reg;
        d = dvd_reg;
        for (int k = 0; k < DIV_STEP_BITS; k++)
        begin
            r = {r[NB_W-1:0], d[HASH_W-1]};
            d = {d[HASH_W-2:0], 1'b0};
            if (r >= dsor)
            begin
                r = r - dsor;
            end
        end
        rem_next = r;
        dvd_next = d;
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (start)
        begin
            step_reg <= DIV_CNT_W'(DIV_STEPS);
        end
        else if (step_reg != '0)
        begin
            step_reg <= step_reg - DIV_CNT_W'(1);
        end
    end

    // dividend shifter and partial remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (step_reg != '0)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign done = (step_reg == '0);
    assign rem  = rem_reg[NB_W-1:0];

endmodule

`default_nettype wire

// File: hw/rtl/bfe_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module bfe_datapath
    import bfe_pkg::*;
#(
    parameter int MAX_BITS = 65536,
    parameter int NB_W     = $clog2(MAX_BITS + 1)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dp_cmd_t           cmd,
    output dp_stat_t               stat,
    input  wire logic [HASH_W-1:0] key_murmur_hash,
    input  wire logic [HASH_W-1:0] key_fnv_hash,
    input  wire logic [HASH_W-1:0] key_crc_hash,
    input  wire logic [NB_W-1:0]   nbits
);

    localparam int DEPTH  = (MAX_BITS / 8 > 0) ? MAX_BITS / 8 : 1;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BY_W   = NB_W - 3;

    logic [HASH_W-1:0] acc_reg;
    logic [HASH_W-1:0] h2_reg;
    logic [HASH_W-1:0] h2_sel;
    logic [HASH_W-1:0] mix_a;
    logic [HASH_W-1:0] mix_prod;
    logic [HASH_W-1:0] prod_reg;
    logic [HASH_W-1:0] dividend;
    logic              div_done;
    logic [NB_W-1:0]   rem;
    logic [BY_W-1:0]   byte_idx;
    logic              byte_ok;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] addr_reg;
    logic [2:0]        bit_sel_reg;
    logic              addr_ok_reg;
    logic [7:0]        rd_data_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              clr_last;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [7:0]        store_mem [DEPTH];

    // second base hash: fnv, else crc, else the golden constant
    always_comb
    begin
        if (key_fnv_hash != '0)
        begin
            h2_sel = key_fnv_hash;
        end
        else if (key_crc_hash != '0)
        begin
            h2_sel = key_crc_hash;
        end
        else
        begin
            h2_sel = GOLDEN;
        end
    end

    // first mixing half: xor-shift then multiply, registered
    assign mix_a    = acc_reg ^ (acc_reg >> MIX_SHIFT_A);
    assign mix_prod = mix_a * GOLDEN;
    assign dividend = prod_reg ^ (prod_reg >> MIX_SHIFT_B);

    // probe hash accumulator h1 + i*h2 and mix register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            acc_reg <= key_murmur_hash;
            h2_reg  <= h2_sel;
        end
        else if (cmd.next_probe)
        begin
            acc_reg <= acc_reg + h2_reg;
        end
        if (cmd.mix)
        begin
            prod_reg <= mix_prod;
        end
    end

    bfe_mod_unit #(
        .NB_W (NB_W)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (nbits),
        .done     (div_done),
        .rem      (rem)
    );

    // bit index to byte address
    assign byte_idx = rem[NB_W-1:3];
    assign byte_ok  = (32'(byte_idx) < 32'(DEPTH));
    assign rd_addr  = ADDR_W'(byte_idx);

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            addr_reg    <= rd_addr;
            bit_sel_reg <= rem[2:0];
            addr_ok_reg <= byte_ok;
        end
    end

    // clearing sweep address
    assign clr_last = (clr_addr_reg == ADDR_W'(DEPTH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_addr_reg <= clr_last ? '0 : clr_addr_reg + ADDR_W'(1);
        end
    end

    // write port shared by the sweep and bit setting
    assign wr_en   = cmd.clr_step | (cmd.set_bit & addr_ok_reg);
    assign wr_addr = cmd.clr_step ? clr_addr_reg : addr_reg;
    assign wr_data = cmd.clr_step ? 8'h00 : (rd_data_reg | (8'b1 << bit_sel_reg));

    // bit store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign stat.div_done = div_done;
    assign stat.bit_hit  = rd_data_reg[bit_sel_reg];
    assign stat.addr_ok  = addr_ok_reg;
    assign stat.clr_last = clr_last;

endmodule

`default_nettype wire

// File: hw/rtl/bfe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

`include "bloom_filter_engine_defines.svh"

module bfe_ctrl
    import bfe_pkg::*;
#(
    parameter int PRB_W = 5
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [1:0]       mode,
    input  wire logic             nbits_zero,
    input  wire logic [PRB_W-1:0] nprobes,
    input  wire dp_stat_t         stat,
    output dp_cmd_t               cmd,
    output logic                  busy,
    output logic                  done,
    output logic                  maybe_present
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_MIX    = 3'd2;
    localparam logic [2:0] S_DSTART = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_CHECK  = 3'd5;
    localparam logic [2:0] S_CLEAR  = 3'd6;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [PRB_W-1:0] probe_reg;
    logic [PRB_W-1:0] probe_next;
    logic             query_reg;
    logic             query_next;
    logic             done_reg;
    logic             ans_reg;
    logic             fin;
    logic             ans;
    logic             last_probe;

    assign last_probe = (probe_reg == nprobes - PRB_W'(1));

    // sequencer: per probe mix, modulo, read, then test or set
    always_comb
    begin
        state_next = state_reg;
        probe_next = probe_reg;
        query_next = query_reg;
        cmd        = '0;
        fin        = 1'b0;
        ans        = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    probe_next = '0;
                    query_next = (mode == MODE_QUERY);
                    unique case (mode) inside
                        MODE_ADD, MODE_QUERY:
                        begin
                            if (nbits_zero || nprobes == '0)
                            begin
                                fin = 1'b1;
                                ans = (mode == MODE_QUERY);
                            end
                            else
                            begin
                                state_next = S_MIX;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            state_next = S_CLEAR;
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_MIX:
            begin
                cmd.mix    = 1'b1;
                state_next = S_DSTART;
            end
            S_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.set_bit = !query_reg;
                if (query_reg && (!stat.addr_ok || !stat.bit_hit))
                begin
                    fin        = 1'b1;
                    state_next = S_IDLE;
                end
                else if (last_probe)
                begin
                    fin        = 1'b1;
                    ans        = query_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.next_probe = 1'b1;
                    probe_next     = probe_reg + PRB_W'(1);
                    state_next     = S_MIX;
                end
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    fin        = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            probe_reg <= '0;
            query_reg <= 1'b0;
            done_reg  <= 1'b0;
            ans_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            probe_reg <= probe_next;
            query_reg <= query_next;
            done_reg  <= fin;
            ans_reg   <= fin & ans;
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign maybe_present = ans_reg;

    `BFE_CHECK(a_done_in_idle, done_reg |-> (state_reg == S_IDLE), "result strobe outside idle")
    `BFE_CHECK(a_accept_moves, (start && !busy) |=> (done_reg || busy), "accepted item lost")
    `BFE_CHECK_ALWAYS(a_answer_strobed, ans_reg |-> done_reg, "answer set without strobe")

endmodule

`default_nettype wire

// File: hw/rtl/bloom_filter_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// bloom filter engine with double hashing over an on-chip bit store
// items: pulse start with mode and the three key hashes while busy is low;
//   the item is taken at that edge. mode add sets the probed bits, query
//   tests them, clear zeroes the whole store, any other mode is done at once
// results: done is high for one cycle with maybe_present; the receiver
//   cannot hold a result off and none is ever dropped
// timing: each probe runs mix (xor-shift and multiply), a modulo by the bit
//   count at 4 bits per cycle, one store read, then test or set; a query
//   stops at its first clear bit, and zero bits or zero probes answer on
//   the next cycle
// clear sweeps the store one byte per cycle over all MAX_BITS/8 bytes, then done
// reset: control and config registers clear at once, then busy stays high
//   for a sweep over all MAX_BITS/8 bytes while the store is zeroed
// configuration: cfg_wr_en writes cfg_data to register cfg_index (0 bit
//   count, 1 hash count) at a clock edge; write only while idle
module bloom_filter_engine
    import bfe_pkg::*;
#(
    parameter int MAX_BITS   = 65536,
    parameter int MAX_PROBES = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [1:0]             mode,
    input  wire logic [HASH_W-1:0]      key_murmur_hash,
    input  wire logic [HASH_W-1:0]      key_fnv_hash,
    input  wire logic [HASH_W-1:0]      key_crc_hash,
    output logic                        done,
    output logic                        maybe_present,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    localparam int NB_W  = $clog2(MAX_BITS + 1);
    localparam int PRB_W = $clog2(MAX_PROBES + 1);

    logic [BIT_COUNT_W-1:0]  bit_count_reg;
    logic [HASH_COUNT_W-1:0] hash_count_reg;
    logic [NB_W-1:0]         nbits;
    logic [PRB_W-1:0]        nprobes;
    logic                    nbits_zero;
    dp_cmd_t                 cmd;
    dp_stat_t                stat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg  <= '0;
            hash_count_reg <= HASH_COUNT_W'(1);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_BIT_COUNT:  bit_count_reg  <= cfg_data[BIT_COUNT_W-1:0];
                REG_HASH_COUNT: hash_count_reg <= cfg_data[HASH_COUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // saturate the settings to the store size and probe limit
    always_comb
    begin
        if (32'(bit_count_reg) > 32'(MAX_BITS))
        begin
            nbits = NB_W'(MAX_BITS);
        end
        else
        begin
            nbits = NB_W'(bit_count_reg);
        end
        if (32'(hash_count_reg) > 32'(MAX_PROBES))
        begin
            nprobes = PRB_W'(MAX_PROBES);
        end
        else
        begin
            nprobes = PRB_W'(hash_count_reg);
        end
    end

    assign nbits_zero = (nbits == '0);

    bfe_ctrl #(
        .PRB_W (PRB_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .mode          (mode),
        .nbits_zero    (nbits_zero),
        .nprobes       (nprobes),
        .stat          (stat),
        .cmd           (cmd),
        .busy          (busy),
        .done          (done),
        .maybe_present (maybe_present)
    );

    bfe_datapath #(
        .MAX_BITS (MAX_BITS),
        .NB_W     (NB_W)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .key_murmur_hash (key_murmur_hash),
        .key_fnv_hash    (key_fnv_hash),
        .key_crc_hash    (key_crc_hash),
        .nbits           (nbits)
    );

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps

// checks the bloom filter engine item by item against a behavioral filter
module tb;
    import bfe_pkg::*;

    localparam int          FILTER_BITS  = 65536;
    localparam int          PROBE_LIMIT  = 16;
    localparam logic [1:0]  MODE_UNUSED  = 2'd3;
    localparam int          LIMIT_CYCLES = 3_000_000;
    localparam int          PHASE_ITEMS  = 153;
    localparam int          KEY_POOL_MAX = 64;

    typedef struct packed {
        logic [31:0] murmur;
        logic [31:0] fnv;
        logic [31:0] crc;
    } key_hashes_t;

    // behavioral filter plus the queue of answers still to come
    class bloom_scoreboard;
        bit                filter_bits [FILTER_BITS];
        bit [16:0]         bit_count;
        bit [4:0]          hash_count;
        bit                expected_present [$];
        int unsigned       failures;

        function new();
            foreach (filter_bits[b])
                filter_bits[b] = 1'b0;
            bit_count  = '0;
            hash_count = 5'd1;
            failures   = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] value);
            if (idx == REG_BIT_COUNT)
                bit_count = value[BIT_COUNT_W-1:0];
            else if (idx == REG_HASH_COUNT)
                hash_count = value[HASH_COUNT_W-1:0];
        endfunction

        // filter bit addressed by probe i of a key
        function bit [31:0] probe_bit(bit [31:0] h1, bit [31:0] h2, bit [31:0] i,
                                      bit [31:0] nbits);
            bit [31:0] x;
            x = h1 + i * h2;
            x = x ^ (x >> MIX_SHIFT_A);
            x = x * GOLDEN;
            x = x ^ (x >> MIX_SHIFT_B);
            return x % nbits;
        endfunction

        function void note_item(logic [1:0] op, key_hashes_t key);
            bit [31:0] nbits;
            bit [31:0] nprobes;
            bit [31:0] h2;
            bit [31:0] b;
            bit        answer;
            nbits   = (bit_count > FILTER_BITS) ? FILTER_BITS : bit_count;
            nprobes = (hash_count > PROBE_LIMIT) ? PROBE_LIMIT : hash_count;
            h2      = key.fnv;
            answer  = 1'b0;
            if (h2 == 0)
                h2 = (key.crc != 0) ? key.crc : GOLDEN;
            if (op == MODE_ADD) begin
                if (nbits != 0) begin
                    for (int i = 0; i < nprobes; i++) begin
                        b = probe_bit(key.murmur, h2, i, nbits);
                        filter_bits[b] = 1'b1;
                    end
                end
            end else if (op == MODE_QUERY) begin
                answer = 1'b1;
                if (nbits != 0) begin
                    for (int i = 0; i < nprobes; i++) begin
                        b = probe_bit(key.murmur, h2, i, nbits);
                        if (!filter_bits[b])
                            answer = 1'b0;
                    end
                end
            end else if (op == MODE_CLEAR) begin
                foreach (filter_bits[k])
                    filter_bits[k] = 1'b0;
            end
            expected_present.insert(expected_present.size(), answer);
        endfunction

        function void check_result(logic actual);
            bit want;
            if (expected_present.size() == 0) begin
                $error("maybe_present: no item outstanding, got %0b", actual);
                failures++;
                return;
            end
            want = expected_present.pop_front();
            if (actual !== want) begin
                $error("maybe_present: expected %0b, got %0b", want, actual);
                failures++;
            end
        endfunction

        function int outstanding();
            return expected_present.size();
        endfunction

        function int unsigned total_failures();
            if (expected_present.size() != 0) begin
                $error("maybe_present: %0d results never arrived", expected_present.size());
                failures++;
            end
            return failures;
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic [1:0]             mode = MODE_ADD;
    logic [HASH_W-1:0]      key_murmur_hash = '0;
    logic [HASH_W-1:0]      key_fnv_hash = '0;
    logic [HASH_W-1:0]      key_crc_hash = '0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_BIT_COUNT;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   busy;
    logic                   done;
    logic                   maybe_present;

    bloom_scoreboard filter_check = new();
    key_hashes_t     added_keys [$];
    int              calm_left = 0;
    int unsigned     cycle_count = 0;

    bloom_filter_engine i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .mode            (mode),
        .key_murmur_hash (key_murmur_hash),
        .key_fnv_hash    (key_fnv_hash),
        .key_crc_hash    (key_crc_hash),
        .done            (done),
        .maybe_present   (maybe_present),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // results first, so an answer and a new item at one edge keep their order
    always @(posedge clk)
    begin
        if (rst_n && done)
            filter_check.check_result(maybe_present);
        if (rst_n && start && !busy)
            filter_check.note_item(mode, '{key_murmur_hash, key_fnv_hash, key_crc_hash});
    end

    // present one item and return at the edge that takes it, start left high
    task automatic issue_item(input logic [1:0] op, input key_hashes_t key);
        int gap;
        if (calm_left > 0) begin
            gap = 0;
            calm_left--;
        end else if ($urandom_range(0, 31) == 0) begin
            gap = 0;
            calm_left = $urandom_range(10, 40);
        end else begin
            gap = $urandom_range(0, 5);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start           <= 1'b1;
        mode            <= op;
        key_murmur_hash <= key.murmur;
        key_fnv_hash    <= key.fnv;
        key_crc_hash    <= key.crc;
        do
            @(posedge clk);
        while (busy);
    endtask

    // hold off new items until every answer is back and the block is idle
    task automatic drain();
        start <= 1'b0;
        do
            @(negedge clk);
        while (filter_check.outstanding() != 0 || busy);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        filter_check.set_reg(idx, value);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(input int unsigned bits, input int unsigned probes);
        logic [CFG_W-1:0] probe_word;
        drain();
        // upper bits of the hash count word are junk the block must drop
        probe_word = CFG_W'({$urandom, 5'd0});
        probe_word[HASH_COUNT_W-1:0] = HASH_COUNT_W'(probes);
        write_reg(REG_BIT_COUNT, CFG_W'(bits));
        write_reg(REG_HASH_COUNT, probe_word);
    endtask

    function automatic key_hashes_t random_key();
        key_hashes_t key;
        key.murmur = $urandom;
        key.fnv    = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom;
        key.crc    = (key.fnv == 0 && $urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
        return key;
    endfunction

    // mostly adds and queries, queries often for keys already added
    task automatic random_item();
        key_hashes_t key;
        logic [1:0]  op;
        int          pick;
        pick = $urandom_range(0, 199);
        if (pick == 0)
            op = MODE_CLEAR;
        else if (pick < 3)
            op = MODE_UNUSED;
        else if (pick < 100)
            op = MODE_ADD;
        else
            op = MODE_QUERY;
        if (op == MODE_QUERY && added_keys.size() != 0 && $urandom_range(0, 1) == 1)
            key = added_keys[$urandom_range(0, added_keys.size() - 1)];
        else
            key = random_key();
        issue_item(op, key);
        if (op == MODE_ADD) begin
            added_keys.insert(added_keys.size(), key);
            if (added_keys.size() > KEY_POOL_MAX)
                void'(added_keys.pop_front());
        end else if (op == MODE_CLEAR) begin
            added_keys.delete();
        end
    endtask

    initial
    begin
        key_hashes_t ones_key;
        key_hashes_t zero_key;
        key_hashes_t crc_key;
        key_hashes_t any_key;
        int unsigned phase_bits [10];
        int unsigned phase_probes [10];

        ones_key     = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
        zero_key     = '{32'd0, 32'd0, 32'd0};
        crc_key      = '{$urandom, 32'd0, $urandom | 32'd1};
        phase_bits   = '{65536, 1000, 131071, 64, 0, 8192, 300, 65535, 17, 2048};
        phase_probes = '{3, 4, 16, 31, 5, 0, 7, 1, 16, 2};

        // reset
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset settings give zero bits, so everything is present
        issue_item(MODE_QUERY, random_key());
        issue_item(MODE_ADD, ones_key);
        issue_item(MODE_QUERY, ones_key);

        // full store, most probes
        configure(65536, 16);
        issue_item(MODE_QUERY, ones_key);
        issue_item(MODE_ADD, ones_key);
        issue_item(MODE_QUERY, ones_key);
        issue_item(MODE_ADD, zero_key);
        issue_item(MODE_QUERY, zero_key);
        issue_item(MODE_ADD, crc_key);
        issue_item(MODE_QUERY, crc_key);
        issue_item(MODE_UNUSED, ones_key);
        issue_item(MODE_QUERY, random_key());
        issue_item(MODE_CLEAR, ones_key);
        issue_item(MODE_QUERY, ones_key);

        // no probes at all
        configure(65536, 0);
        any_key = random_key();
        issue_item(MODE_ADD, any_key);
        issue_item(MODE_QUERY, any_key);

        // oversized registers saturate
        configure(131071, 31);
        issue_item(MODE_ADD, ones_key);
        issue_item(MODE_QUERY, ones_key);
        issue_item(MODE_QUERY, zero_key);

        // one bit, store contents kept from the earlier items
        configure(1, 1);
        issue_item(MODE_QUERY, random_key());
        issue_item(MODE_ADD, random_key());
        issue_item(MODE_QUERY, random_key());

        // random phases across settings
        for (int p = 0; p < 10; p++) begin
            configure(phase_bits[p], phase_probes[p]);
            added_keys.delete();
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_item();
        end

        // wind down
        drain();
        repeat (20) @(posedge clk);
        if (filter_check.total_failures() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/bfe_pkg.sv
hw/rtl/bfe_mod_unit.sv
hw/rtl/bfe_datapath.sv
hw/rtl/bfe_ctrl.sv
hw/rtl/bloom_filter_engine.sv
bench/tb.sv
